>>> rtl/core/int64_to_decimal_ascii_defines.svh
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii_defines
// Assertion macros for the decimal text converter.
// ----------------------------------------------------------------------------
`ifndef INT64_TO_DECIMAL_ASCII_DEFINES_SVH
`define INT64_TO_DECIMAL_ASCII_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define I64DA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define I64DA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define I64DA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define I64DA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/i64da_pkg.sv
// ----------------------------------------------------------------------------
// i64da_pkg
// Constants shared by the decimal text converter.
// ----------------------------------------------------------------------------
package i64da_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int IN_WIDTH    = 64;
    // decimal digits needed for VALUE_WIDTH bits: floor(W * log10(2)) + 1
    localparam int C_NDIG      = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int C_BCD_W     = C_NDIG * 4;
    localparam int C_BCNT_W    = $clog2(VALUE_WIDTH + 1);
    localparam int C_DCNT_W    = $clog2(C_NDIG + 1);
    localparam int CHAR_W      = 6;

    localparam logic [CHAR_W-1:0] C_CH_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] C_CH_MINUS = 6'd45;

    localparam logic OP_SIGNED   = 1'b0;
    localparam logic OP_UNSIGNED = 1'b1;

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [C_BCD_W-1:0]     t_bcd;

endpackage

>>> rtl/core/int64_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii
// Binary to ASCII decimal text converter, signed or unsigned, one character
// per output beat.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready): one beat carries i_opcode and
// i_value_bits. o_ready is high only while the block is idle.
// Output channel (o_valid / i_ready): one beat per character, most
// significant first, '-' ahead of a negative signed value; o_last_char marks
// the final character of the value.
// Sequence: the value is converted bit-serially by shift-and-add-3, one bit per
// cycle, over all VALUE_WIDTH (64) bits. Then the sign beat, if the value is
// negative, is sent, and the C_NDIG (20) digit positions are walked in turn,
// leading zeros being dropped without a beat.
// A receiver stall holds the current character; the block waits with it.
// Reset (synchronous, active low) returns the block to idle and drops any
// value in progress.
// ----------------------------------------------------------------------------
`include "int64_to_decimal_ascii_defines.svh"

module int64_to_decimal_ascii
    import i64da_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_opcode,
    input  logic [IN_WIDTH-1:0] i_value_bits,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CHAR_W-1:0]   o_char_code,
    output logic                o_last_char
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_SIGN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [C_BCNT_W-1:0] r_bcnt,  n_bcnt;
    logic [C_DCNT_W-1:0] r_dcnt,  n_dcnt;
    logic                r_neg,   n_neg;
    logic                r_lead,  n_lead;
    t_value              r_bin,   n_bin;
    t_bcd                r_bcd,   n_bcd;

    t_value     w_raw;
    t_value     w_mag;
    logic       w_neg;
    t_bcd       w_adj;
    logic [3:0] w_top;
    logic       w_show;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_raw = i_value_bits[VALUE_WIDTH-1:0];
    assign w_neg = (i_opcode == OP_SIGNED) && w_raw[VALUE_WIDTH-1];
    assign w_mag = w_neg ? t_value'(~w_raw + t_value'(1)) : w_raw;

    always_comb begin
        for (int i = 0; i < C_NDIG; i++) begin
            w_adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= 4'd5) ? r_bcd[i*4 +: 4] + 4'd3
                                                         : r_bcd[i*4 +: 4];
        end
    end

    assign w_top  = r_bcd[C_BCD_W-1 -: 4];
    assign w_show = !r_lead || (w_top != 4'd0) || (r_dcnt == C_DCNT_W'(1));

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_SIGN) || ((r_state == S_EMIT) && w_show);
    assign o_char_code = (r_state == S_SIGN) ? C_CH_MINUS : C_CH_ZERO + {2'b00, w_top};
    assign o_last_char = (r_state == S_EMIT) && (r_dcnt == C_DCNT_W'(1));

    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;

    always_comb begin
        n_state = r_state;
        n_bcnt  = r_bcnt;
        n_dcnt  = r_dcnt;
        n_neg   = r_neg;
        n_lead  = r_lead;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_CONV;
                    n_bin   = w_mag;
                    n_bcd   = '0;
                    n_neg   = w_neg;
                    n_bcnt  = C_BCNT_W'(VALUE_WIDTH);
                end
            end
            S_CONV: begin
                n_bcd  = {w_adj[C_BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin  = {r_bin[VALUE_WIDTH-2:0], 1'b0};
                n_bcnt = r_bcnt - C_BCNT_W'(1);
                n_dcnt = C_DCNT_W'(C_NDIG);
                n_lead = 1'b1;
                if (r_bcnt == C_BCNT_W'(1)) begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (w_out_acc) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!w_show || w_out_acc) begin
                    n_bcd  = {r_bcd[C_BCD_W-5:0], 4'd0};
                    n_dcnt = r_dcnt - C_DCNT_W'(1);
                    n_lead = r_lead && !w_show;
                    if (r_dcnt == C_DCNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bcnt  <= '0;
            r_dcnt  <= '0;
            r_lead  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_bcnt  <= n_bcnt;
            r_dcnt  <= n_dcnt;
            r_lead  <= n_lead;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    `I64DA_ASSERT_NEXT(a_acc_starts_conv, i_clk, i_rst_n, w_in_acc, r_state == S_CONV)
    `I64DA_ASSERT_NOW(a_minus_not_last, i_clk, i_rst_n,
        o_valid && (o_char_code == C_CH_MINUS), !o_last_char)
    `I64DA_ASSERT_NOW(a_char_range, i_clk, i_rst_n, o_valid,
        (o_char_code == C_CH_MINUS) ||
        ((o_char_code >= C_CH_ZERO) && (o_char_code <= C_CH_ZERO + 6'd9)))
    `I64DA_ASSERT_NEXT(a_last_ends_item, i_clk, i_rst_n,
        w_out_acc && o_last_char, r_state == S_IDLE)

endmodule
